### rtl/core/cord_pkg.sv
// Shared types and constants for the CORDIC sine/cosine pipeline.
// No dependencies; used by cord_stage, cordic_sine_cosine and cord_chk.
`default_nettype none

package cord_pkg;

    localparam int DATA_W = 32;
    localparam int ITER_W = 6;
    localparam int LUT_DEPTH = 32;
    localparam int LUT_IDX_W = 5;

    // Gain-compensated start value of x (1/K scaled by 2^30)
    localparam logic signed [DATA_W-1:0] GAIN_INIT = 32'sh26DD3B6A;
    localparam logic [ITER_W-1:0] ITER_RESET = 6'd32;

    // atan(2^-k) scaled by 2^30
    localparam logic [DATA_W-1:0] ATAN_LUT [LUT_DEPTH] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

    // Payload that travels down the pipeline with each beat
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic        [ITER_W-1:0] n;
    } cord_data_t;

endpackage : cord_pkg

`default_nettype wire

### rtl/core/cordic_sine_cosine.sv
// Top level of the pipelined rotation-mode CORDIC sine/cosine unit.
// Depends on cord_pkg and cord_stage.
//
//  channel  | ports                              | role
//  ---------+------------------------------------+---------------------------
//  input    | s_valid, s_ready, s_angle          | angle, rad * 2^30
//  result   | m_valid, m_ready, m_sine, m_cosine | sin/cos * 2^30
//  config   | cfg_wr_en, cfg_wr_data             | iteration count, no wait
//
// One beat enters per cycle while s_ready is high; a result is offered once its
// angle has passed through the stage registers, one register stage per
// CORDIC iteration (one add/sub per stage).
// Iterations beyond the configured count pass through their stage unchanged.
// Reset clears all stage valid bits and sets the iteration count to 32.
// A stall at m_ready holds the last stage; ready ripples back through the
// stages in the same cycle, so bubbles still fill and s_ready drops only
// when every stage holds a beat.
`default_nettype none

module cordic_sine_cosine import cord_pkg::*; #(
    parameter int MAX_STAGES = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [ITER_W-1:0]        cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [DATA_W-1:0] s_angle,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_sine,
    output logic signed [DATA_W-1:0]      m_cosine
);

    localparam logic [ITER_W-1:0] STAGE_LIMIT = ITER_W'(MAX_STAGES);

    logic [ITER_W-1:0] iterations_reg;
    logic [ITER_W-1:0] iterations_next;
    logic [ITER_W-1:0] iter_eff;

    logic       stg_valid [MAX_STAGES+1];
    logic       stg_ready [MAX_STAGES+1];
    cord_data_t stg_data  [MAX_STAGES+1];

    // Write the iteration count register
    assign iterations_next = cfg_wr_en ? cfg_wr_data : iterations_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iterations_reg <= ITER_RESET;
        end else begin
            iterations_reg <= iterations_next;
        end
    end

    // Clamp the count to the number of built stages
    assign iter_eff = (iterations_reg > STAGE_LIMIT) ? STAGE_LIMIT : iterations_reg;

    // Seed the pipeline: x at the gain constant, y at zero, z at the angle
    assign stg_valid[0]  = s_valid;
    assign s_ready       = stg_ready[0];
    assign stg_data[0].x = GAIN_INIT;
    assign stg_data[0].y = '0;
    assign stg_data[0].z = s_angle;
    assign stg_data[0].n = iter_eff;

    // One stage per iteration
    for (genvar i = 0; i < MAX_STAGES; i++) begin : g_stage
        cord_stage #(
            .STAGE_IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    // Last stage register drives the result channel
    assign stg_ready[MAX_STAGES] = m_ready;
    assign m_valid  = stg_valid[MAX_STAGES];
    assign m_sine   = stg_data[MAX_STAGES].y;
    assign m_cosine = stg_data[MAX_STAGES].x;

endmodule : cordic_sine_cosine

`default_nettype wire

### rtl/core/cord_stage.sv
// One registered CORDIC rotation stage with a valid/ready handshake.
// Depends on cord_pkg for the payload type and the arctangent table.
`default_nettype none

module cord_stage import cord_pkg::*; #(
    parameter int STAGE_IDX = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire cord_data_t in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output cord_data_t      out_data
);

    localparam logic [LUT_IDX_W-1:0] LUT_IDX = LUT_IDX_W'(STAGE_IDX);
    localparam logic [ITER_W-1:0]    K_IDX   = ITER_W'(STAGE_IDX);
    localparam logic signed [DATA_W-1:0] ATAN_K = ATAN_LUT[LUT_IDX];

    logic       valid_reg;
    logic       valid_next;
    cord_data_t data_reg;
    cord_data_t data_next;

    logic signed [DATA_W-1:0] xs;
    logic signed [DATA_W-1:0] ys;
    logic                     active;

    // Take a new beat when empty or when the current one leaves
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // One micro-rotation; pass through once past the iteration count
    always_comb begin
        xs        = in_data.x >>> STAGE_IDX;
        ys        = in_data.y >>> STAGE_IDX;
        active    = K_IDX < in_data.n;
        data_next = in_data;
        if (active) begin
            if (in_data.z[DATA_W-1]) begin
                data_next.x = in_data.x + ys;
                data_next.y = in_data.y - xs;
                data_next.z = in_data.z + ATAN_K;
            end else begin
                data_next.x = in_data.x - ys;
                data_next.y = in_data.y + xs;
                data_next.z = in_data.z - ATAN_K;
            end
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    // Advance valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on an accepted beat, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule : cord_stage

`default_nettype wire

### rtl/core/cord_chk.sv
// Port-level checker for cordic_sine_cosine, attached by the bind below.
// Depends on cord_pkg for field widths.
`default_nettype none

module cord_chk import cord_pkg::*; #(
    parameter int MAX_STAGES = 32
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic signed [DATA_W-1:0] m_sine,
    input wire logic signed [DATA_W-1:0] m_cosine
);

    localparam int CNT_W = $clog2(MAX_STAGES + 2);

    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // Track beats accepted but not yet delivered
    always_comb begin
        pend_next = pend_reg;
        if (in_beat && !out_beat) begin
            pend_next = pend_reg + CNT_W'(1);
        end else if (!in_beat && out_beat) begin
            pend_next = pend_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // No result without a pending input beat
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != '0)
        else $error("result shown with no pending input");

    // Never more beats in flight than stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= CNT_W'(MAX_STAGES))
        else $error("more beats in flight than stages");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sine) && $stable(m_cosine))
        else $error("stalled result changed");

endmodule : cord_chk

bind cordic_sine_cosine cord_chk #(
    .MAX_STAGES (MAX_STAGES)
) u_cord_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_sine   (m_sine),
    .m_cosine (m_cosine)
);

`default_nettype wire
